### rtl/core/ffsd_pkg.sv
// ----------------------------------------------------------------------------
// ffsd_pkg
// shared types and constants for the flow first-seen detector
// ----------------------------------------------------------------------------
package ffsd_pkg;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;

	localparam int KEY_W = 104;

	// byte 0 of the hash key sits in the low bits
	typedef struct packed {
		logic [7:0]  protocol;
		logic [15:0] dport;
		logic [15:0] sport;
		logic [31:0] dst_addr;
		logic [31:0] src_addr;
	} key_t;

	typedef struct packed {
		logic valid;
		key_t key;
	} slot_t;

	typedef enum logic [1:0] {
		OUT_NEW     = 2'd0,
		OUT_PRESENT = 2'd1,
		OUT_FULL    = 2'd2
	} outcome_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_PRIME,
		ST_PROBE,
		ST_DONE
	} ctl_state_t;

	typedef enum logic [1:0] {
		H_IDLE,
		H_ROUND,
		H_MOD,
		H_DONE
	} hash_state_t;

endpackage

### rtl/core/ffsd_hash_unit.sv
// ----------------------------------------------------------------------------
// ffsd_hash_unit
// byte-serial fnv-1a over the 13-byte key zero-padded to 16 bytes, then a
// reciprocal-multiply reduction by the table size on the same multiplier
// (skipped when the table size is a power of two)
// ----------------------------------------------------------------------------
module ffsd_hash_unit
	import ffsd_pkg::*;
#(
	parameter int TABLE_SLOTS = 8192
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  key_t                           key,
	output logic                           done,
	output logic [$clog2(TABLE_SLOTS)-1:0] idx
);

	localparam int  SLOT_W     = $clog2(TABLE_SLOTS);
	localparam bit  SLOTS_POW2 = ((1 << SLOT_W) == TABLE_SLOTS);
	localparam logic [31:0] SLOTS_32 = 32'(TABLE_SLOTS);
	// floor(2^32 / TABLE_SLOTS): the quotient estimate is low by at most one
	localparam logic [31:0] RECIP    = 32'((64'd1 << 32) / 64'(TABLE_SLOTS));

	hash_state_t        hstate_q, hstate_d;
	logic [3:0]         round_q;
	logic               mod_step_q;
	logic [127:0]       bytes_q;
	logic [31:0]        h_q;
	logic [31:0]        h_mix;
	logic [31:0]        quot_q;
	logic [31:0]        rem_q;
	logic [31:0]        rem_fix;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        mul_p;

	// one fnv round: xor the byte, multiply modulo 2^32
	assign h_mix = h_q ^ {24'd0, bytes_q[7:0]};

	// the one shared multiplier: fnv rounds, then quotient estimate, then
	// quotient times table size
	always_comb begin
		mul_a = h_mix;
		mul_b = FNV_PRIME;
		if (hstate_q == H_MOD) begin
			if (mod_step_q) begin
				mul_a = quot_q;
				mul_b = SLOTS_32;
			end else begin
				mul_a = h_q;
				mul_b = RECIP;
			end
		end
	end

	assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

	// remainder estimate is below twice the table size, one subtract fixes it
	assign rem_fix = (rem_q >= SLOTS_32) ? (rem_q - SLOTS_32) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hstate_q <= H_IDLE;
		end else begin
			hstate_q <= hstate_d;
		end
	end

	always_comb begin
		hstate_d = hstate_q;
		case (hstate_q)
			H_IDLE: begin
				if (start) hstate_d = H_ROUND;
			end
			H_ROUND: begin
				if (round_q == 4'hf) hstate_d = SLOTS_POW2 ? H_DONE : H_MOD;
			end
			H_MOD: begin
				if (mod_step_q) hstate_d = H_DONE;
			end
			H_DONE: begin
				hstate_d = H_IDLE;
			end
			default: hstate_d = H_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (hstate_q)
			H_IDLE: begin
				h_q        <= FNV_BASIS;
				bytes_q    <= {24'd0, key};
				round_q    <= '0;
				mod_step_q <= 1'b0;
			end
			H_ROUND: begin
				h_q     <= mul_p[31:0];
				bytes_q <= {8'd0, bytes_q[127:8]};
				round_q <= round_q + 4'd1;
			end
			H_MOD: begin
				mod_step_q <= 1'b1;
				if (mod_step_q) begin
					rem_q <= h_q - mul_p[31:0];
				end else begin
					quot_q <= mul_p[63:32];
				end
			end
			default: begin
			end
		endcase
	end

	assign done = (hstate_q == H_DONE);
	assign idx  = SLOTS_POW2 ? h_q[SLOT_W-1:0] : rem_fix[SLOT_W-1:0];

endmodule

### rtl/core/flow_first_seen_detector.sv
// ----------------------------------------------------------------------------
// flow_first_seen_detector
// first-packet detector over two hash tables of flow 5-tuples
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries one 5-tuple and a table select
//   per beat; output channel (out_valid/out_ready) returns one beat per input
//   with first_seen and outcome (new, already present, window full)
// sequence:
//   one item at a time. after the accept come serial fnv-1a rounds over the
//   16 padded key bytes (one 32x32 multiply per cycle), two more multiplies
//   on that multiplier to reduce the hash when TABLE_SLOTS is not a power of
//   two, a step to hand the index over, one to prime the slot memory read,
//   one per probed slot (1 to PROBE_LIMIT) and one to load the output
//   register; only the number of probes varies from item to item
// reset:
//   after arst_n the slot memory is swept clear, one entry per cycle, over all
//   2 * 2^clog2(TABLE_SLOTS) entries (16384 by default); in_ready stays low
// stall:
//   a result waits in the output register; the next item may be accepted and
//   hashed meanwhile, and it holds in its final state until the register frees
// ----------------------------------------------------------------------------
module flow_first_seen_detector
	import ffsd_pkg::*;
#(
	parameter int TABLE_SLOTS = 8192,
	parameter int PROBE_LIMIT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        table_select,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] sport,
	input  logic [15:0] dport,
	input  logic [7:0]  protocol,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        first_seen,
	output logic [1:0]  outcome
);

	localparam int SLOT_W    = $clog2(TABLE_SLOTS);
	localparam int ADDR_W    = SLOT_W + 1;
	localparam int MEM_DEPTH = 1 << ADDR_W;
	localparam int CNT_W     = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROBE_LIMIT - 1);
	localparam logic [SLOT_W:0]  SLOTS_END = (SLOT_W + 1)'(TABLE_SLOTS);

	ctl_state_t         state_q, state_d;
	logic [ADDR_W-1:0]  clr_q;
	logic               tsel_q;
	key_t               key_q;
	key_t               in_key;
	logic [SLOT_W-1:0]  cur_q;
	logic [SLOT_W-1:0]  cur_next;
	logic [SLOT_W:0]    cur_inc;
	logic [CNT_W-1:0]   cnt_q;
	outcome_t           res_q, res_d;
	logic               out_valid_q;
	outcome_t           outcome_q;
	logic               in_accept;

	// hash unit
	logic               hash_done;
	logic [SLOT_W-1:0]  hash_idx;
	logic [SLOT_W-1:0]  hash_idx_q;

	// slot memory
	slot_t              slot_mem_q [MEM_DEPTH];
	slot_t              rd_q;
	logic [ADDR_W-1:0]  rd_addr;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	slot_t              wr_data;

	// probe decisions on the slot read last cycle
	logic               slot_empty;
	logic               slot_match;
	logic               probe_stop;

	assign in_key.src_addr = src_addr;
	assign in_key.dst_addr = dst_addr;
	assign in_key.sport    = sport;
	assign in_key.dport    = dport;
	assign in_key.protocol = protocol;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_accept = in_valid && in_ready;

	ffsd_hash_unit #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_accept),
		.key    (in_key),
		.done   (hash_done),
		.idx    (hash_idx)
	);

	// linear probe wraps inside the selected table
	assign cur_inc  = {1'b0, cur_q} + 1'b1;
	assign cur_next = (cur_inc == SLOTS_END) ? '0 : cur_inc[SLOT_W-1:0];

	assign slot_empty = !rd_q.valid;
	assign slot_match = rd_q.valid && (rd_q.key == key_q);
	assign probe_stop = slot_empty || slot_match || (cnt_q == CNT_LAST);

	// read address: first slot while priming, then always one slot ahead
	always_comb begin
		case (state_q)
			ST_PRIME: rd_addr = {tsel_q, hash_idx_q};
			ST_PROBE: rd_addr = {tsel_q, cur_next};
			default:  rd_addr = {tsel_q, cur_q};
		endcase
	end

	// the hash index is valid with the done strobe; keep it for the prime read
	always_ff @(posedge clk) begin
		if (hash_done) hash_idx_q <= hash_idx;
	end

	// write port: clearing sweep or insert into the first empty slot
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = {tsel_q, cur_q};
		wr_data = '{valid: 1'b1, key: key_q};
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			ST_PROBE: begin
				wr_en = slot_empty;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) slot_mem_q[wr_addr] <= wr_data;
		rd_q <= slot_mem_q[rd_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_accept) state_d = ST_HASH;
			end
			ST_HASH: begin
				if (hash_done) state_d = ST_PRIME;
			end
			ST_PRIME: begin
				state_d = ST_PROBE;
			end
			ST_PROBE: begin
				if (probe_stop) begin
					state_d = ST_DONE;
					if (slot_empty) begin
						res_d = OUT_NEW;
					end else if (slot_match) begin
						res_d = OUT_PRESENT;
					end else begin
						res_d = OUT_FULL;
					end
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and probe position
	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (in_accept) begin
			tsel_q <= table_select;
			key_q  <= in_key;
		end
		if (state_q == ST_PRIME) begin
			cur_q <= hash_idx_q;
			cnt_q <= '0;
		end else if (state_q == ST_PROBE && !probe_stop) begin
			cur_q <= cur_next;
			cnt_q <= cnt_q + 1'b1;
		end
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) outcome_q <= res_q;
	end

	assign out_valid  = out_valid_q;
	assign outcome    = outcome_q;
	assign first_seen = (outcome_q == OUT_NEW);

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------

	// an accepted beat always starts the hash
	a_accept_hash: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == ST_HASH)
	else $error("accepted beat did not start hashing");

	// probing never runs past the window
	a_probe_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PROBE |-> cnt_q <= CNT_LAST)
	else $error("probe count past window");

	// an insert only lands on a slot that read back empty
	a_insert_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q != ST_CLEAR) |-> (state_q == ST_PROBE && !rd_q.valid))
	else $error("insert over an occupied slot");

	// results carry a legal outcome code
	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (outcome_q == OUT_NEW || outcome_q == OUT_PRESENT ||
			outcome_q == OUT_FULL))
	else $error("illegal outcome code");

endmodule
